@@ rtl/grcw_pkg.sv @@
// grcw_pkg: shared types and constants for the grid ray cell walker
// no dependencies; imported by every module of the block except grcw_fifo
`timescale 1ns / 1ps

package grcw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS_Z = 3'd7;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [63:0] T_INF = 64'h4000_0000_0000_0000;

  localparam int DIV_NUM_W         = 48;
  localparam int DIV_DEN_W         = 32;
  localparam int DIV_BITS_PER_STEP = 2;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic        [30:0] ray_length;
  } ray_t;

  typedef struct packed {
    logic [15:0] cell_index;
    logic [7:0]  cell_col_x;
    logic [7:0]  cell_row_z;
    logic        found;
    logic        last_of_ray;
  } visit_t;

  typedef struct packed {
    logic [2:0][31:0] bound_min;
    logic [2:0][31:0] bound_max;
    logic [8:0]       cells_x;
    logic [8:0]       cells_z;
  } cfg_t;

  typedef struct packed {
    logic             miss;
    logic [7:0]       cell_x;
    logic [7:0]       cell_z;
    logic [8:0]       cnt_x;
    logic [8:0]       cnt_z;
    logic [2:0]       step_pos;
    logic [2:0][63:0] tmax;
    logic [2:0][63:0] tdel;
    logic [30:0]      length;
  } desc_t;

endpackage

@@ rtl/grcw_fifo.sv @@
// grcw_fifo: small register queue with first-word fall-through read
// no package dependencies
`timescale 1ns / 1ps

module grcw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/grcw_div.sv @@
// grcw_div: unsigned restoring divider, two quotient bits per cycle
// depends on grcw_pkg for operand widths
`timescale 1ns / 1ps

module grcw_div import grcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int STEPS = DIV_NUM_W / DIV_BITS_PER_STEP;
  localparam int CW    = $clog2(STEPS);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] nq;
  logic [CW-1:0]        cnt;
  logic                 running;

  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_NUM_W-1:0] nq_next;
  logic [DIV_DEN_W:0]   trial;

  always_comb begin
    rem_next = rem;
    nq_next  = nq;
    trial    = '0;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      trial = {rem_next, nq_next[DIV_NUM_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_next = DIV_DEN_W'(trial - {1'b0, den_r});
        nq_next  = {nq_next[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_next = trial[DIV_DEN_W-1:0];
        nq_next  = {nq_next[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = nq;

  always_ff @(posedge clk) begin
    if (start && !running) begin
      rem   <= '0;
      nq    <= num;
      den_r <= den;
    end else if (running) begin
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == '0);
      if (start && !running) begin
        running <= 1'b1;
        cnt     <= CW'(STEPS - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/grcw_setup.sv @@
// grcw_setup: front end, takes a ray, finds the start cell and per-axis t values
// depends on grcw_pkg and grcw_div
`timescale 1ns / 1ps

module grcw_setup import grcw_pkg::*; #(
  parameter int MAX_GRID_SIDE = 256,
  parameter int CELLS_Y       = 1
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  ray_push,
  input  ray_t  ray,
  output logic  busy,
  output logic  desc_wr,
  output desc_t desc,
  input  logic  desc_full
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SZ   = 4'd1;
  localparam logic [3:0] ST_SZW  = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_CL   = 4'd4;
  localparam logic [3:0] ST_CLW  = 4'd5;
  localparam logic [3:0] ST_BND  = 4'd6;
  localparam logic [3:0] ST_TM   = 4'd7;
  localparam logic [3:0] ST_TMW  = 4'd8;
  localparam logic [3:0] ST_TDW  = 4'd9;
  localparam logic [3:0] ST_PUSH = 4'd10;

  logic [3:0]       st;
  logic [1:0]       ax;
  logic [2:0][31:0] org;
  logic [2:0][31:0] dir;
  logic [30:0]      len;
  logic [8:0]       cnt_x;
  logic [8:0]       cnt_z;
  logic [2:0][31:0] size;
  logic [7:0]       cell_x;
  logic [7:0]       cell_z;
  logic [32:0]      prod;
  logic             neg;
  logic             miss;
  logic [2:0][63:0] tmax;
  logic [2:0][63:0] tdel;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_q;

  logic [33:0] bmin_a;
  logic [33:0] bmax_a;
  logic [33:0] org_a;
  logic [33:0] span;
  logic        span_pos;
  logic [33:0] cl_num;
  logic [8:0]  cnt_a;
  logic [7:0]  cell_a;
  logic [31:0] dir_a;
  logic [31:0] dir_mag;
  logic        dir_nz;
  logic        pos_a;
  logic [8:0]  step_cnt;
  logic [40:0] prod_full;
  logic [33:0] bound;
  logic [33:0] diff;
  logic [33:0] dmag;
  logic [7:0]  q_sat;
  logic        miss_c;
  logic [63:0] tq;
  logic        last_ax;

  function automatic logic [8:0] clamp_count(input logic [8:0] v);
    if (v == '0) begin
      return 9'd1;
    end else if (v > 9'(MAX_GRID_SIDE)) begin
      return 9'(MAX_GRID_SIDE);
    end
    return v;
  endfunction

  grcw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    bmin_a    = {{2{cfg.bound_min[ax][31]}}, cfg.bound_min[ax]};
    bmax_a    = {{2{cfg.bound_max[ax][31]}}, cfg.bound_max[ax]};
    org_a     = {{2{org[ax][31]}}, org[ax]};
    span      = bmax_a - bmin_a;
    span_pos  = !span[33] && (span != '0);
    cl_num    = org_a - bmin_a;
    cnt_a     = (ax == AXIS_X) ? cnt_x : ((ax == AXIS_Z) ? cnt_z : 9'(CELLS_Y));
    cell_a    = (ax == AXIS_X) ? cell_x : ((ax == AXIS_Z) ? cell_z : 8'd0);
    dir_a     = dir[ax];
    dir_mag   = dir_a[31] ? 32'(-dir_a) : dir_a;
    dir_nz    = (dir_a != '0);
    pos_a     = !dir_a[31] && dir_nz;
    step_cnt  = {1'b0, cell_a} + {8'd0, pos_a};
    prod_full = step_cnt * size[ax];
    bound     = bmin_a + {1'b0, prod};
    diff      = bound - org_a;
    dmag      = diff[33] ? 34'(-diff) : diff;
    q_sat     = (div_q >= {39'd0, cnt_a}) ? 8'(cnt_a - 9'd1) : div_q[7:0];
    tq        = {16'd0, div_q};
    last_ax   = (ax == AXIS_Z);
    miss_c    = (size[0] == '0) || (size[2] == '0) ||
                ($signed(org[0]) <  $signed(cfg.bound_min[0])) ||
                ($signed(org[0]) >= $signed(cfg.bound_max[0])) ||
                ($signed(org[2]) <  $signed(cfg.bound_min[2])) ||
                ($signed(org[2]) >= $signed(cfg.bound_max[2]));

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st)
      ST_SZ: begin
        div_start = span_pos;
        div_num   = {16'd0, span[31:0]};
        div_den   = {23'd0, cnt_a};
      end
      ST_CL: begin
        div_start = 1'b1;
        div_num   = {16'd0, cl_num[31:0]};
        div_den   = size[ax];
      end
      ST_TM: begin
        div_start = 1'b1;
        div_num   = {dmag[31:0], 16'd0};
        div_den   = dir_mag;
      end
      ST_TMW: begin
        div_start = div_done;
        div_num   = {size[ax], 16'd0};
        div_den   = dir_mag;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign busy    = (st != ST_IDLE);
  assign desc_wr = (st == ST_PUSH) && !desc_full;

  always_comb begin
    desc.miss     = miss;
    desc.cell_x   = cell_x;
    desc.cell_z   = cell_z;
    desc.cnt_x    = cnt_x;
    desc.cnt_z    = cnt_z;
    desc.step_pos = {!dir[2][31] && (dir[2] != '0),
                     !dir[1][31] && (dir[1] != '0),
                     !dir[0][31] && (dir[0] != '0)};
    desc.tmax     = tmax;
    desc.tdel     = tdel;
    desc.length   = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      ax <= AXIS_X;
    end else begin
      case (st)
        ST_IDLE: begin
          if (ray_push) begin
            org   <= {ray.origin_z, ray.origin_y, ray.origin_x};
            dir   <= {ray.dir_z, ray.dir_y, ray.dir_x};
            len   <= ray.ray_length;
            cnt_x <= clamp_count(cfg.cells_x);
            cnt_z <= clamp_count(cfg.cells_z);
            ax    <= AXIS_X;
            st    <= ST_SZ;
          end
        end
        ST_SZ: begin
          if (span_pos) begin
            st <= ST_SZW;
          end else begin
            size[ax] <= '0;
            ax       <= last_ax ? AXIS_X : ax + 2'd1;
            st       <= last_ax ? ST_CHK : ST_SZ;
          end
        end
        ST_SZW: begin
          if (div_done) begin
            size[ax] <= div_q[31:0];
            ax       <= last_ax ? AXIS_X : ax + 2'd1;
            st       <= last_ax ? ST_CHK : ST_SZ;
          end
        end
        ST_CHK: begin
          miss <= miss_c;
          ax   <= AXIS_X;
          st   <= miss_c ? ST_PUSH : ST_CL;
        end
        ST_CL: begin
          st <= ST_CLW;
        end
        ST_CLW: begin
          if (div_done) begin
            if (ax == AXIS_X) begin
              cell_x <= q_sat;
              ax     <= AXIS_Z;
              st     <= ST_CL;
            end else begin
              cell_z <= q_sat;
              ax     <= AXIS_X;
              st     <= ST_BND;
            end
          end
        end
        ST_BND: begin
          if (dir_nz && (size[ax] != '0)) begin
            prod <= prod_full[32:0];
            st   <= ST_TM;
          end else begin
            tmax[ax] <= T_INF;
            tdel[ax] <= T_INF;
            ax       <= last_ax ? AXIS_X : ax + 2'd1;
            st       <= last_ax ? ST_PUSH : ST_BND;
          end
        end
        ST_TM: begin
          neg <= diff[33] ^ dir_a[31];
          st  <= ST_TMW;
        end
        ST_TMW: begin
          if (div_done) begin
            tmax[ax] <= neg ? 64'(-tq) : tq;
            st       <= ST_TDW;
          end
        end
        ST_TDW: begin
          if (div_done) begin
            tdel[ax] <= tq;
            ax       <= last_ax ? AXIS_X : ax + 2'd1;
            st       <= last_ax ? ST_PUSH : ST_BND;
          end
        end
        ST_PUSH: begin
          if (!desc_full) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/grcw_walk.sv @@
// grcw_walk: back end, steps a prepared ray cell by cell and emits visits
// depends on grcw_pkg
`timescale 1ns / 1ps

module grcw_walk import grcw_pkg::*; #(
  parameter int MAX_CELLS = 16,
  parameter int CELLS_Y   = 1
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   desc_empty,
  input  desc_t  desc,
  output logic   desc_rd,
  output logic   out_wr,
  output visit_t out_item,
  input  logic   out_full
);

  localparam int NW = $clog2(MAX_CELLS + 1);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_MISS = 2'd1;
  localparam logic [1:0] W_STEP = 2'd2;
  localparam logic [1:0] W_CHK  = 2'd3;

  logic [1:0]       st;
  logic [NW-1:0]    n;
  logic [9:0]       cx;
  logic [9:0]       cy;
  logic [9:0]       cz;
  logic [7:0]       px;
  logic [7:0]       pz;
  logic [2:0][63:0] tm;
  logic [2:0][63:0] td;
  logic [63:0]      trav;
  logic [30:0]      len;
  logic [8:0]       cntx;
  logic [8:0]       cntz;
  logic [2:0]       spos;

  logic             lt01;
  logic             lt02;
  logic             lt12;
  logic [1:0]       sel;
  logic [2:0][63:0] tsum;
  logic [9:0]       delta;
  logic             cap;
  logic             cond;
  logic [7:0]       ex;
  logic [7:0]       ez;
  logic [16:0]      idx;

  always_comb begin
    lt01 = $signed(tm[0]) < $signed(tm[1]);
    lt02 = $signed(tm[0]) < $signed(tm[2]);
    lt12 = $signed(tm[1]) < $signed(tm[2]);
    sel  = (lt01 && lt02) ? AXIS_X : (lt12 ? AXIS_Y : AXIS_Z);
    for (int a = 0; a < 3; a++) begin
      tsum[a] = tm[a] + td[a];
    end
    delta = spos[sel] ? 10'd1 : 10'h3FF;
    cap   = (n == NW'(MAX_CELLS - 1));
    cond  = ($signed(trav) <= $signed({33'd0, len})) &&
            !cx[9] && (cx < {1'b0, cntx}) &&
            !cy[9] && (cy < 10'(CELLS_Y)) &&
            !cz[9] && (cz < {1'b0, cntz});
    ex    = (st == W_CHK) ? px : cx[7:0];
    ez    = (st == W_CHK) ? pz : cz[7:0];
    idx   = ez * cntx + {9'd0, ex};
  end

  assign desc_rd = (st == W_IDLE) && !desc_empty;

  always_comb begin
    out_wr               = 1'b0;
    out_item.cell_index  = idx[15:0];
    out_item.cell_col_x  = ex;
    out_item.cell_row_z  = ez;
    out_item.found       = 1'b1;
    out_item.last_of_ray = 1'b1;
    case (st)
      W_MISS: begin
        out_wr               = !out_full;
        out_item.cell_index  = '0;
        out_item.cell_col_x  = '0;
        out_item.cell_row_z  = '0;
        out_item.found       = 1'b0;
      end
      W_STEP: begin
        out_wr = cap && !out_full;
      end
      W_CHK: begin
        out_wr               = !out_full;
        out_item.last_of_ray = !cond;
      end
      default: begin
        out_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= W_IDLE;
      n  <= '0;
    end else begin
      case (st)
        W_IDLE: begin
          if (!desc_empty) begin
            cx   <= {2'd0, desc.cell_x};
            cy   <= '0;
            cz   <= {2'd0, desc.cell_z};
            tm   <= desc.tmax;
            td   <= desc.tdel;
            trav <= '0;
            len  <= desc.length;
            cntx <= desc.cnt_x;
            cntz <= desc.cnt_z;
            spos <= desc.step_pos;
            n    <= '0;
            st   <= desc.miss ? W_MISS : W_STEP;
          end
        end
        W_MISS: begin
          if (!out_full) begin
            st <= W_IDLE;
          end
        end
        W_STEP: begin
          if (cap) begin
            if (!out_full) begin
              st <= W_IDLE;
            end
          end else begin
            px   <= cx[7:0];
            pz   <= cz[7:0];
            trav <= tm[sel];
            if ($signed(tm[sel]) < $signed(T_INF)) begin
              tm[sel] <= tsum[sel];
            end
            case (sel)
              AXIS_X:  cx <= cx + delta;
              AXIS_Y:  cy <= cy + delta;
              default: cz <= cz + delta;
            endcase
            st <= W_CHK;
          end
        end
        W_CHK: begin
          if (!out_full) begin
            n  <= n + 1'b1;
            st <= cond ? W_STEP : W_IDLE;
          end
        end
        default: begin
          st <= W_IDLE;
        end
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) out_wr |-> !out_full)
    else $error("visit pushed into a full queue");

  a_cell_inside: assert property (@(posedge clk) disable iff (rst)
    (st == W_STEP) |-> (!cx[9] && !cz[9] && (cx < {1'b0, cntx}) && (cz < {1'b0, cntz})))
    else $error("stepping from a cell outside the grid");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (st != W_IDLE) |-> (n <= NW'(MAX_CELLS - 1)))
    else $error("visit count past its cap");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_wr && out_item.last_of_ray) |=> (st == W_IDLE))
    else $error("walk continues after the final visit");

endmodule

@@ rtl/grid_ray_cell_walker.sv @@
// grid_ray_cell_walker: top level, configuration registers and the two queues
// depends on grcw_pkg, grcw_fifo, grcw_setup and grcw_walk
//
// channel  | direction | handshake       | payload
// ray      | in        | push / full     | ray_t
// visit    | out       | pop / empty     | visit_t
// cfg      | in        | cfg_wen         | cfg_addr, cfg_wdata
//
// setup runs its divides on the one shared two-bit-per-cycle divider: up to three for cell
// sizes, two for the origin cell and up to six for tMax and tDelta
// the walker then takes each visited cell through a step state and a check state, up to MAX_CELLS cells
// a two-entry queue lets the next request's setup overlap the current walk
// synchronous reset; full stays high while the setup unit holds a request
`timescale 1ns / 1ps

module grid_ray_cell_walker import grcw_pkg::*; #(
  parameter int MAX_CELLS     = 16,
  parameter int CELLS_Y       = 1,
  parameter int MAX_GRID_SIDE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ray_t                  ray,
  output logic                  empty,
  input  logic                  pop,
  output visit_t                visit,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  logic   busy;
  logic   desc_wr;
  desc_t  desc_in;
  logic   desc_full;
  logic   desc_rd;
  desc_t  desc_out;
  logic   desc_empty;
  logic   out_wr;
  visit_t out_item;
  logic   out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bound_min <= {32'd0, 32'd0, 32'd0};
      cfg.bound_max <= {32'd65536, 32'd65536, 32'd65536};
      cfg.cells_x   <= 9'd1;
      cfg.cells_z   <= 9'd1;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_BOUND_MIN_X:    cfg.bound_min[0] <= cfg_wdata;
        REG_BOUND_MIN_Y:    cfg.bound_min[1] <= cfg_wdata;
        REG_BOUND_MIN_Z:    cfg.bound_min[2] <= cfg_wdata;
        REG_BOUND_MAX_X:    cfg.bound_max[0] <= cfg_wdata;
        REG_BOUND_MAX_Y:    cfg.bound_max[1] <= cfg_wdata;
        REG_BOUND_MAX_Z:    cfg.bound_max[2] <= cfg_wdata;
        REG_CELLS_ACROSS_X: cfg.cells_x      <= cfg_wdata[8:0];
        REG_CELLS_ACROSS_Z: cfg.cells_z      <= cfg_wdata[8:0];
        default:            cfg.cells_z      <= cfg.cells_z;
      endcase
    end
  end

  assign full = busy;

  grcw_setup #(
    .MAX_GRID_SIDE (MAX_GRID_SIDE),
    .CELLS_Y       (CELLS_Y)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ray_push  (push && !busy),
    .ray       (ray),
    .busy      (busy),
    .desc_wr   (desc_wr),
    .desc      (desc_in),
    .desc_full (desc_full)
  );

  grcw_fifo #(
    .W     ($bits(desc_t)),
    .DEPTH (2)
  ) u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (desc_wr),
    .wdata (desc_in),
    .full  (desc_full),
    .rd    (desc_rd),
    .rdata (desc_out),
    .empty (desc_empty)
  );

  grcw_walk #(
    .MAX_CELLS (MAX_CELLS),
    .CELLS_Y   (CELLS_Y)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .desc_empty (desc_empty),
    .desc       (desc_out),
    .desc_rd    (desc_rd),
    .out_wr     (out_wr),
    .out_item   (out_item),
    .out_full   (out_full)
  );

  grcw_fifo #(
    .W     ($bits(visit_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_wr),
    .wdata (out_item),
    .full  (out_full),
    .rd    (pop),
    .rdata (visit),
    .empty (empty)
  );

endmodule

@@ test/testbench.sv @@
// testbench: grid ray cell walker, rays pushed in phases of grid settings
// a scoreboard class predicts the visited cells of each accepted request; needs grcw_pkg
`timescale 1ns / 1ps

module testbench;
  import grcw_pkg::*;

  localparam longint T_HUGE = longint'(1) <<< 62;
  localparam int CAP_CELLS = 16;
  localparam int CYCLE_LIMIT = 1000000;

  class walk_scoreboard;
    bit [31:0] reg_val[8];
    visit_t    cells_due[$];
    int        errors;

    function new();
      reg_val[REG_BOUND_MIN_X] = 0;
      reg_val[REG_BOUND_MIN_Y] = 0;
      reg_val[REG_BOUND_MIN_Z] = 0;
      reg_val[REG_BOUND_MAX_X] = 65536;
      reg_val[REG_BOUND_MAX_Y] = 65536;
      reg_val[REG_BOUND_MAX_Z] = 65536;
      reg_val[REG_CELLS_ACROSS_X] = 1;
      reg_val[REG_CELLS_ACROSS_Z] = 1;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(int idx, bit [31:0] d);
      reg_val[idx] = (idx >= REG_CELLS_ACROSS_X) ? (d & 32'h1FF) : d;
    endfunction

    function longint grid_count(bit [31:0] v);
      if (v < 1) return 1;
      if (v > 256) return 256;
      return longint'(v);
    endfunction

    function visit_t make_visit(longint x, longint z, longint cx, bit fnd);
      visit_t v;
      v.cell_index = 16'(z * cx + x);
      v.cell_col_x = 8'(x);
      v.cell_row_z = 8'(z);
      v.found = fnd;
      v.last_of_ray = 1'b0;
      return v;
    endfunction

    function void note_ray(ray_t r);
      longint bmin[3], bmax[3], org[3], dir[3], cnt[3], sz[3];
      longint cur[3], stp[3], tmax[3], tdel[3];
      longint len, trav, bnd, mag, span;
      int n, ax;
      visit_t walk[$];
      for (int a = 0; a < 3; a++) begin
        bmin[a] = longint'($signed(reg_val[a]));
        bmax[a] = longint'($signed(reg_val[3 + a]));
      end
      org[0] = longint'(r.origin_x); org[1] = longint'(r.origin_y);
      org[2] = longint'(r.origin_z);
      dir[0] = longint'(r.dir_x); dir[1] = longint'(r.dir_y); dir[2] = longint'(r.dir_z);
      len = longint'(r.ray_length);
      cnt[0] = grid_count(reg_val[REG_CELLS_ACROSS_X]);
      cnt[1] = 1;
      cnt[2] = grid_count(reg_val[REG_CELLS_ACROSS_Z]);
      for (int a = 0; a < 3; a++) begin
        span = bmax[a] - bmin[a];
        sz[a] = (span > 0) ? span / cnt[a] : 0;
      end
      if (sz[0] == 0 || sz[2] == 0 || org[0] < bmin[0] || org[0] >= bmax[0] ||
          org[2] < bmin[2] || org[2] >= bmax[2]) begin
        walk.push_back(make_visit(0, 0, 1, 1'b0));
      end else begin
        cur[0] = (org[0] - bmin[0]) / sz[0];
        cur[1] = 0;
        cur[2] = (org[2] - bmin[2]) / sz[2];
        if (cur[0] >= cnt[0]) cur[0] = cnt[0] - 1;
        if (cur[2] >= cnt[2]) cur[2] = cnt[2] - 1;
        for (int a = 0; a < 3; a++) begin
          stp[a] = (dir[a] > 0) ? 1 : -1;
          if (dir[a] != 0 && sz[a] != 0) begin
            bnd = bmin[a] + (cur[a] + ((stp[a] > 0) ? 1 : 0)) * sz[a];
            mag = (dir[a] < 0) ? -dir[a] : dir[a];
            tmax[a] = ((bnd - org[a]) * 65536) / dir[a];
            tdel[a] = (sz[a] * 65536) / mag;
          end else begin
            tmax[a] = T_HUGE;
            tdel[a] = T_HUGE;
          end
        end
        trav = 0;
        n = 0;
        while (trav <= len) begin
          if (cur[0] < 0 || cur[0] >= cnt[0] || cur[1] < 0 || cur[1] >= cnt[1] ||
              cur[2] < 0 || cur[2] >= cnt[2]) break;
          walk.push_back(make_visit(cur[0], cur[2], cnt[0], 1'b1));
          n++;
          if (n >= CAP_CELLS) break;
          if (tmax[0] < tmax[1] && tmax[0] < tmax[2]) ax = 0;
          else if (tmax[1] < tmax[2]) ax = 1;
          else ax = 2;
          cur[ax] += stp[ax];
          trav = tmax[ax];
          if (tmax[ax] < T_HUGE) tmax[ax] += tdel[ax];
        end
      end
      walk[walk.size() - 1].last_of_ray = 1'b1;
      foreach (walk[i]) cells_due.push_back(walk[i]);
    endfunction

    task check_visit(visit_t v);
      visit_t e;
      if (cells_due.size() == 0) begin
        report($sformatf("unexpected result %h", v));
        return;
      end
      e = cells_due.pop_front();
      if (v.cell_index != e.cell_index || v.cell_col_x != e.cell_col_x ||
          v.cell_row_z != e.cell_row_z || v.found != e.found ||
          v.last_of_ray != e.last_of_ray)
        report($sformatf("idx %0d/%0d x %0d/%0d z %0d/%0d found %0d/%0d last %0d/%0d",
                         v.cell_index, e.cell_index, v.cell_col_x, e.cell_col_x,
                         v.cell_row_z, e.cell_row_z, v.found, e.found,
                         v.last_of_ray, e.last_of_ray));
    endtask
  endclass

  logic clk, rst, push, full, empty, pop, cfg_wen;
  ray_t ray;
  visit_t visit;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  walk_scoreboard sb;
  int send_idle_pct, pop_stall_pct;
  int cycles;

  grid_ray_cell_walker uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .ray(ray),
    .empty(empty), .pop(pop), .visit(visit),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    push = 0; pop = 0; ray = '0; cfg_wen = 0; cfg_addr = '0; cfg_wdata = '0;
    rst = 1;
    sb = new();
    send_idle_pct = 0;
    pop_stall_pct = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
  initial cycles = 0;

  // result side
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_visit(visit);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task load_grid(bit [31:0] vals[8]);
    logic [CFG_IDX_W-1:0] idx[8];
    idx = '{REG_BOUND_MIN_X, REG_BOUND_MIN_Y, REG_BOUND_MIN_Z, REG_BOUND_MAX_X,
            REG_BOUND_MAX_Y, REG_BOUND_MAX_Z, REG_CELLS_ACROSS_X, REG_CELLS_ACROSS_Z};
    for (int i = 0; i < 8; i++) begin
      cfg_wen <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_wen <= 1'b0;
  endtask

  task send_ray(ray_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    ray <= r;
    do @(posedge clk); while (full);
    sb.note_ray(r);
  endtask

  task drain();
    push <= 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function bit [31:0] rand_dir();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom;
      2: return $urandom_range(1, 32'h4_0000);
      3: return -$urandom_range(1, 32'h4_0000);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? $urandom_range(1, 32'h2000)
                                           : -$urandom_range(1, 32'h2000);
    endcase
  endfunction

  function bit [31:0] rand_inside(int a);
    longint lo, span;
    lo = longint'($signed(sb.reg_val[a]));
    span = longint'($signed(sb.reg_val[3 + a])) - lo;
    if (span <= 0 || $urandom_range(9) == 0) return $urandom;
    return 32'(lo + (longint'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF) % span));
  endfunction

  function ray_t rand_ray();
    ray_t r;
    r.origin_x = rand_inside(0);
    r.origin_y = rand_inside(1);
    r.origin_z = rand_inside(2);
    r.dir_x = rand_dir();
    r.dir_y = rand_dir();
    r.dir_z = rand_dir();
    case ($urandom_range(3))
      0: r.ray_length = 31'($urandom);
      1: r.ray_length = 31'h7FFF_FFFF;
      default: r.ray_length = 31'($urandom_range(0, 32'h20_0000));
    endcase
    return r;
  endfunction

  function ray_t mk(bit [31:0] ox, bit [31:0] oy, bit [31:0] oz, bit [31:0] dx,
                    bit [31:0] dy, bit [31:0] dz, bit [30:0] len);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz; r.ray_length = len;
    return r;
  endfunction

  initial begin
    bit [31:0] grid[8];
    ray_t r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 56; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 56; end
        default: begin send_idle_pct = 17; pop_stall_pct = 17; end
      endcase
      case (ph)
        1: grid = '{0, 0, 0, 32'h8_0000, 32'h8_0000, 32'h8_0000, 8, 8};
        2: grid = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 256, 256};
        3: grid = '{-32'h3_8000, 32'h1_0000, -32'h3_8000, 32'h5_4000, 32'h1_0000,
                    32'h5_4000, 7, 5};
        4: grid = '{0, 0, 0, 32'h10_0000, 32'h10_0000, 32'h10_0000, 0, 511};
        5: grid = '{32'h2_0000, 0, 0, 32'h2_0000, 32'h1_0000, 32'h4_0000, 4, 4};
        6: grid = '{0, 0, 0, 32'h4_0000, 32'h1_0000, 100, 4, 256};
        7: begin
          for (int a = 0; a < 3; a++) begin
            grid[a] = $urandom;
            grid[3 + a] = 32'(longint'($signed(grid[a])) + $urandom_range(1, 32'h40_0000));
            if ($signed(grid[3 + a]) < $signed(grid[a])) grid[3 + a] = 32'h7FFF_FFFF;
          end
          grid[6] = $urandom_range(1, 256);
          grid[7] = $urandom_range(1, 256);
        end
        default: ;
      endcase
      if (ph != 0) load_grid(grid);

      if (ph == 1) begin
        // min edge, max edge, outside, zero dirs, axis ties, extremes
        send_ray(mk(0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 31'h7FFF_FFFF));
        send_ray(mk(32'h7_FFFF, 0, 32'h7_FFFF, -32'h1_0000, 0, -32'h1_0000, 31'h7FFF_FFFF));
        send_ray(mk(32'h8_0000, 0, 0, 32'h1_0000, 0, 0, 100));
        send_ray(mk(0, 0, 32'h8_0000, 0, 0, 32'h1_0000, 100));
        send_ray(mk(-1, 0, 0, 32'h1_0000, 0, 0, 100));
        send_ray(mk(0, 0, -1, 32'h1_0000, 0, 0, 100));
        send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 0, 0, 0, 31'h7FFF_FFFF));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 32'h1_0000, 32'h1_0000,
                    32'h1_0000, 31'h7FFF_FFFF));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 32'h1_0000, 0, 32'h1_0000,
                    31'h7FFF_FFFF));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 0, 32'h1_0000, 32'h1_0000,
                    31'h7FFF_FFFF));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                    31'h7FFF_FFFF));
        send_ray(mk(32'h4_8000, 32'h8000, 32'h4_8000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_ray(mk(32'h1000, 0, 32'h1000, 1, 0, 2, 31'h7FFF_FFFF));
        send_ray(mk(32'h1000, 0, 32'h1000, 32'h1_0000, 0, 32'h3000, 0));
        send_ray(mk(32'h1000, 0, 32'h1000, 32'h1_0000, 0, 32'h3000, 32'h1_0000));
        send_ray(mk(32'h7_F000, 32'h7_FFFF, 32'h7_F000, -32'h10, 32'h10, -32'h11,
                    31'h7FFF_FFFF));
        send_ray(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
      end

      for (int i = 0; i < 20; i++) begin
        r = rand_ray();
        send_ray(r);
      end
      drain();
    end

    if (sb.cells_due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.cells_due.size()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/grcw_pkg.sv
rtl/grcw_fifo.sv
rtl/grcw_div.sv
rtl/grcw_setup.sv
rtl/grcw_walk.sv
rtl/grid_ray_cell_walker.sv
test/testbench.sv
